FILE: rtl/core/tlra_pkg.sv
// Shared types, constants and decode functions for the tensor layout reorder
// address core. No dependencies; every other file in rtl/core uses this package.
package tlra_pkg;

  // Channel block of the blocked layouts and the clamp on the channel counts.
  localparam int BLOCK      = 16;
  localparam int BLOCK_LOG2 = 4;
  localparam int MAX_EXTENT = 4096;

  // Field widths.
  localparam int GRP_W   = 10;
  localparam int IDX_W   = 12;
  localparam int SPA_W   = 10;
  localparam int OFS_W   = 32;
  localparam int ACT_W   = 2;
  localparam int MODE_W  = 4;
  localparam int GCNT_W  = 11;
  localparam int CNT_W   = 13;
  localparam int DIM_W   = 11;
  localparam int BLKC_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Horner steps per offset and the width of one step's operands.
  localparam int STEPS   = 6;
  localparam int MULT_W  = 13;
  localparam int DIGIT_W = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd5;

  // Layout pairs, destination from source.
  localparam logic [MODE_W-1:0] MODE_NCHW_FROM_NHWC     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_NHWC_FROM_NCHW     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_NCHW_FROM_CBLK     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CBLK_FROM_NCHW     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_WBLK_FROM_OIHW     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_GWBLK_FROM_GOIHW   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_OIHW_FROM_WBLK     = 4'd6;
  localparam logic [MODE_W-1:0] MODE_GOIHW_FROM_GWBLK   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_OIHW_FROM_HWIO     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_GOIHW_FROM_GHWIO   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_HWIO_FROM_OIHW     = 4'd10;
  localparam logic [MODE_W-1:0] MODE_GHWIO_FROM_GOIHW   = 4'd11;

  typedef enum logic [ACT_W-1:0] {
    ACT_COPY = 2'd0,
    ACT_ZERO = 2'd1,
    ACT_SKIP = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    LAY_PLAIN,
    LAY_NHWC,
    LAY_HWIO,
    LAY_CBLK,
    LAY_WBLK
  } layout_t;

  typedef struct packed {
    logic [GRP_W-1:0] g;
    logic [IDX_W-1:0] o;
    logic [IDX_W-1:0] i;
    logic [SPA_W-1:0] y;
    logic [SPA_W-1:0] x;
  } coord_t;

  // Effective extents: clamped counts and their block counts.
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  c;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  w;
    logic [BLKC_W-1:0] ob;
    logic [BLKC_W-1:0] ib;
  } dims_t;

  typedef struct packed {
    logic             known;
    layout_t          src_lay;
    layout_t          dst_lay;
    logic             grouped;
    logic             pad_o;
    logic             pad_i;
    logic             zero_pad;
  } mode_info_t;

  // Per-item control that rides along the offset pipeline.
  typedef struct packed {
    layout_t src_lay;
    layout_t dst_lay;
    action_t act;
  } ctl_t;

  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [DIGIT_W-1:0] digit;
  } term_t;

  function automatic mode_info_t mode_info(logic [MODE_W-1:0] m);
    mode_info_t r;
    r.known    = 1'b1;
    r.src_lay  = LAY_PLAIN;
    r.dst_lay  = LAY_PLAIN;
    r.grouped  = (m == MODE_GWBLK_FROM_GOIHW) || (m == MODE_GOIHW_FROM_GWBLK) ||
                 (m == MODE_GOIHW_FROM_GHWIO) || (m == MODE_GHWIO_FROM_GOIHW);
    r.pad_o    = (m >= MODE_WBLK_FROM_OIHW) && (m <= MODE_GOIHW_FROM_GWBLK);
    r.pad_i    = (m >= MODE_NCHW_FROM_CBLK) && (m <= MODE_GOIHW_FROM_GWBLK);
    r.zero_pad = (m >= MODE_CBLK_FROM_NCHW) && (m <= MODE_GWBLK_FROM_GOIHW);
    case (m)
      MODE_NCHW_FROM_NHWC:   r.src_lay = LAY_NHWC;
      MODE_NHWC_FROM_NCHW:   r.dst_lay = LAY_NHWC;
      MODE_NCHW_FROM_CBLK:   r.src_lay = LAY_CBLK;
      MODE_CBLK_FROM_NCHW:   r.dst_lay = LAY_CBLK;
      MODE_WBLK_FROM_OIHW,
      MODE_GWBLK_FROM_GOIHW: r.dst_lay = LAY_WBLK;
      MODE_OIHW_FROM_WBLK,
      MODE_GOIHW_FROM_GWBLK: r.src_lay = LAY_WBLK;
      MODE_OIHW_FROM_HWIO,
      MODE_GOIHW_FROM_GHWIO: r.src_lay = LAY_HWIO;
      MODE_HWIO_FROM_OIHW,
      MODE_GHWIO_FROM_GOIHW: r.dst_lay = LAY_HWIO;
      default:               r.known = 1'b0;
    endcase
    return r;
  endfunction

  // Leading term of the Horner chain.
  function automatic logic [OFS_W-1:0] start_value(layout_t lay, coord_t c);
    logic [OFS_W-1:0] r;
    case (lay)
      LAY_NHWC, LAY_CBLK: r = OFS_W'(c.o);
      default:            r = OFS_W'(c.g);
    endcase
    return r;
  endfunction

  // Multiplier and addend of Horner step k; short chains lead with identity steps.
  function automatic term_t step_term(layout_t lay, logic [2:0] k, coord_t c, dims_t d);
    term_t id;
    term_t t_n;
    term_t t_c;
    term_t t_h;
    term_t t_w;
    term_t t_ob;
    term_t t_ib;
    term_t t_il;
    term_t t_ol;
    term_t r;
    id   = '{mult: MULT_W'(1), digit: '0};
    t_n  = '{mult: d.n, digit: c.o};
    t_c  = '{mult: d.c, digit: c.i};
    t_h  = '{mult: MULT_W'(d.h), digit: DIGIT_W'(c.y)};
    t_w  = '{mult: MULT_W'(d.w), digit: DIGIT_W'(c.x)};
    t_ob = '{mult: MULT_W'(d.ob), digit: DIGIT_W'(c.o >> BLOCK_LOG2)};
    t_ib = '{mult: MULT_W'(d.ib), digit: DIGIT_W'(c.i >> BLOCK_LOG2)};
    t_il = '{mult: MULT_W'(BLOCK), digit: DIGIT_W'(c.i[BLOCK_LOG2-1:0])};
    t_ol = '{mult: MULT_W'(BLOCK), digit: DIGIT_W'(c.o[BLOCK_LOG2-1:0])};
    r = id;
    case (lay)
      LAY_NHWC: begin
        case (k)
          3'd3:    r = t_h;
          3'd4:    r = t_w;
          3'd5:    r = t_c;
          default: r = id;
        endcase
      end
      LAY_HWIO: begin
        case (k)
          3'd2:    r = t_h;
          3'd3:    r = t_w;
          3'd4:    r = t_c;
          3'd5:    r = t_n;
          default: r = id;
        endcase
      end
      LAY_CBLK: begin
        case (k)
          3'd2:    r = t_ib;
          3'd3:    r = t_h;
          3'd4:    r = t_w;
          3'd5:    r = t_il;
          default: r = id;
        endcase
      end
      LAY_WBLK: begin
        case (k)
          3'd0:    r = t_ob;
          3'd1:    r = t_ib;
          3'd2:    r = t_h;
          3'd3:    r = t_w;
          3'd4:    r = t_il;
          3'd5:    r = t_ol;
          default: r = id;
        endcase
      end
      default: begin
        case (k)
          3'd2:    r = t_n;
          3'd3:    r = t_c;
          3'd4:    r = t_h;
          3'd5:    r = t_w;
          default: r = id;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/tlra_req_if.sv
// Coordinate request channel: valid/ready handshake plus one element coordinate.
// Depends on tlra_pkg for field widths.
interface tlra_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlra_pkg::GRP_W-1:0]  group_idx;
  logic [tlra_pkg::IDX_W-1:0]  outer_idx;
  logic [tlra_pkg::IDX_W-1:0]  inner_idx;
  logic [tlra_pkg::SPA_W-1:0]  row_idx;
  logic [tlra_pkg::SPA_W-1:0]  col_idx;

  modport source (output valid, group_idx, outer_idx, inner_idx, row_idx, col_idx,
                  input ready);
  modport sink (input valid, group_idx, outer_idx, inner_idx, row_idx, col_idx,
                output ready);
endinterface

FILE: rtl/core/tlra_rsp_if.sv
// Address result channel: valid/ready handshake plus the offset pair and action.
// Depends on tlra_pkg for field widths.
interface tlra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tlra_pkg::OFS_W-1:0]  src_offset;
  logic [tlra_pkg::OFS_W-1:0]  dst_offset;
  logic [tlra_pkg::ACT_W-1:0]  action;

  modport source (output valid, src_offset, dst_offset, action, input ready);
  modport sink (input valid, src_offset, dst_offset, action, output ready);
endinterface

FILE: rtl/core/tensor_layout_reorder_addr_core.sv
// Top level of the tensor layout reorder address core.
// Depends on tlra_pkg, tlra_req_if and tlra_rsp_if.
//
// Address generator for a layout reorder stream. Each coordinate transfer on
// req (group, outer, inner, row, col) yields exactly one transfer on rsp with
// the source and destination element offsets (modulo 2^32) and an action:
// copy, write zero to a padded destination lane, or skip. The block takes one
// coordinate per clock while rsp is not stalled; each result passes one input
// register, one decode stage that checks ranges and picks the layouts, then six
// stages, each one 32x13 multiply-add of the Horner chain for both offsets. Every
// stage has its own valid bit and only holds while the stage after it is full and
// stalled, so bubbles collapse and req keeps taking transfers while a finished
// result waits on rsp, as long as some stage is empty. Registers are written
// through cfg_we/cfg_index/cfg_wdata (index 0 mode, 1 group_count, 2 outer_count,
// 3 inner_count, 4 height, 5 width; other indexes are ignored) and must only change
// while no transfer is in flight. Reset leaves mode 0 and all counts at 1.
// outer_count and inner_count above 4096 are clamped to 4096; unused modes and
// zero counts (group_count only in grouped modes) skip every coordinate.
module tensor_layout_reorder_addr_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tlra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlra_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  tlra_req_if.sink                             req,
  tlra_rsp_if.source                           rsp
);

  // Stage 0 input register, stage 1 decode, stages 2..7 multiply-add.
  localparam int LAST = tlra_pkg::STEPS + 1;

  // Configuration registers.
  logic [tlra_pkg::MODE_W-1:0] mode;
  logic [tlra_pkg::GCNT_W-1:0] group_count;
  logic [tlra_pkg::CNT_W-1:0]  outer_count;
  logic [tlra_pkg::CNT_W-1:0]  inner_count;
  logic [tlra_pkg::DIM_W-1:0]  height;
  logic [tlra_pkg::DIM_W-1:0]  width;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= tlra_pkg::MODE_NCHW_FROM_NHWC;
      group_count <= tlra_pkg::GCNT_W'(1);
      outer_count <= tlra_pkg::CNT_W'(1);
      inner_count <= tlra_pkg::CNT_W'(1);
      height      <= tlra_pkg::DIM_W'(1);
      width       <= tlra_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tlra_pkg::REG_MODE:        mode        <= cfg_wdata[tlra_pkg::MODE_W-1:0];
        tlra_pkg::REG_GROUP_COUNT: group_count <= cfg_wdata[tlra_pkg::GCNT_W-1:0];
        tlra_pkg::REG_OUTER_COUNT: outer_count <= cfg_wdata[tlra_pkg::CNT_W-1:0];
        tlra_pkg::REG_INNER_COUNT: inner_count <= cfg_wdata[tlra_pkg::CNT_W-1:0];
        tlra_pkg::REG_HEIGHT:      height      <= cfg_wdata[tlra_pkg::DIM_W-1:0];
        tlra_pkg::REG_WIDTH:       width       <= cfg_wdata[tlra_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective extents, live: user keeps config quiet with items in flight; unenforced.
  tlra_pkg::dims_t            dims;
  logic [tlra_pkg::CNT_W-1:0] n_pad;
  logic [tlra_pkg::CNT_W-1:0] c_pad;
  logic [tlra_pkg::CNT_W:0]   n_sum;
  logic [tlra_pkg::CNT_W:0]   c_sum;

  always_comb begin
    dims.n = (outer_count > tlra_pkg::CNT_W'(tlra_pkg::MAX_EXTENT)) ?
             tlra_pkg::CNT_W'(tlra_pkg::MAX_EXTENT) : outer_count;
    dims.c = (inner_count > tlra_pkg::CNT_W'(tlra_pkg::MAX_EXTENT)) ?
             tlra_pkg::CNT_W'(tlra_pkg::MAX_EXTENT) : inner_count;
    dims.h = height;
    dims.w = width;
    n_sum  = {1'b0, dims.n} + (tlra_pkg::CNT_W+1)'(tlra_pkg::BLOCK - 1);
    c_sum  = {1'b0, dims.c} + (tlra_pkg::CNT_W+1)'(tlra_pkg::BLOCK - 1);
    dims.ob = tlra_pkg::BLKC_W'(n_sum >> tlra_pkg::BLOCK_LOG2);
    dims.ib = tlra_pkg::BLKC_W'(c_sum >> tlra_pkg::BLOCK_LOG2);
    n_pad  = tlra_pkg::CNT_W'(dims.ob) << tlra_pkg::BLOCK_LOG2;
    c_pad  = tlra_pkg::CNT_W'(dims.ib) << tlra_pkg::BLOCK_LOG2;
  end

  // Pipeline registers.
  logic                        vld [0:LAST];
  logic                        en  [0:LAST];
  tlra_pkg::coord_t            crd [0:LAST-1];
  tlra_pkg::ctl_t              ctl [1:LAST];
  logic [tlra_pkg::OFS_W-1:0]  acc_src [1:LAST];
  logic [tlra_pkg::OFS_W-1:0]  acc_dst [1:LAST];

  // A stage loads when it is empty or the one after it loads.
  always_comb begin
    en[LAST] = !vld[LAST] || rsp.ready;
    for (int p = LAST - 1; p >= 0; p--) begin
      en[p] = !vld[p] || en[p+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p <= LAST; p++) begin
        vld[p] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld[0] <= req.valid;
      end
      for (int p = 1; p <= LAST; p++) begin
        if (en[p]) begin
          vld[p] <= vld[p-1];
        end
      end
    end
  end

  // Stage 0: hold the accepted coordinate.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      crd[0].g <= req.group_idx;
      crd[0].o <= req.outer_idx;
      crd[0].i <= req.inner_idx;
      crd[0].y <= req.row_idx;
      crd[0].x <= req.col_idx;
    end
  end

  // Stage 1: range checks, action and layout selection.
  tlra_pkg::mode_info_t        info;
  tlra_pkg::ctl_t              ctl_next;
  logic [tlra_pkg::CNT_W-1:0]  o_ext;
  logic [tlra_pkg::CNT_W-1:0]  i_ext;
  logic                        in_range;
  logic                        real_lane;

  always_comb begin
    info  = tlra_pkg::mode_info(mode);
    o_ext = info.pad_o ? n_pad : dims.n;
    i_ext = info.pad_i ? c_pad : dims.c;
    in_range = ({1'b0, crd[0].y} < height) && ({1'b0, crd[0].x} < width) &&
               ({1'b0, crd[0].o} < o_ext) && ({1'b0, crd[0].i} < i_ext) &&
               (info.grouped ? ({1'b0, crd[0].g} < group_count) : (crd[0].g == '0));
    real_lane = ({1'b0, crd[0].o} < dims.n) && ({1'b0, crd[0].i} < dims.c);
    ctl_next.src_lay = info.src_lay;
    ctl_next.dst_lay = info.dst_lay;
    if (!info.known || !in_range) begin
      ctl_next.act = tlra_pkg::ACT_SKIP;
    end else if (real_lane) begin
      ctl_next.act = tlra_pkg::ACT_COPY;
    end else if (info.zero_pad) begin
      ctl_next.act = tlra_pkg::ACT_ZERO;
    end else begin
      ctl_next.act = tlra_pkg::ACT_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      crd[1]     <= crd[0];
      ctl[1]     <= ctl_next;
      acc_src[1] <= tlra_pkg::start_value(info.src_lay, crd[0]);
      acc_dst[1] <= tlra_pkg::start_value(info.dst_lay, crd[0]);
    end
  end

  // Stages 2..7: one Horner multiply-add per stage for each offset.
  for (genvar k = 0; k < tlra_pkg::STEPS; k++) begin : g_step
    tlra_pkg::term_t                           t_src;
    tlra_pkg::term_t                           t_dst;
    logic [tlra_pkg::OFS_W+tlra_pkg::MULT_W-1:0] prod_src;
    logic [tlra_pkg::OFS_W+tlra_pkg::MULT_W-1:0] prod_dst;
    logic [tlra_pkg::OFS_W-1:0]                src_next;
    logic [tlra_pkg::OFS_W-1:0]                dst_next;

    always_comb begin
      t_src    = tlra_pkg::step_term(ctl[k+1].src_lay, 3'(k), crd[k+1], dims);
      t_dst    = tlra_pkg::step_term(ctl[k+1].dst_lay, 3'(k), crd[k+1], dims);
      prod_src = acc_src[k+1] * t_src.mult;
      prod_dst = acc_dst[k+1] * t_dst.mult;
      src_next = prod_src[tlra_pkg::OFS_W-1:0] + tlra_pkg::OFS_W'(t_src.digit);
      dst_next = prod_dst[tlra_pkg::OFS_W-1:0] + tlra_pkg::OFS_W'(t_dst.digit);
      // Last step: drop offsets the action does not use.
      if (k == tlra_pkg::STEPS - 1) begin
        if (ctl[k+1].act != tlra_pkg::ACT_COPY) begin
          src_next = '0;
        end
        if (ctl[k+1].act == tlra_pkg::ACT_SKIP) begin
          dst_next = '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        ctl[k+2]     <= ctl[k+1];
        acc_src[k+2] <= src_next;
        acc_dst[k+2] <= dst_next;
      end
    end

    if (k + 2 < LAST) begin : g_crd
      always_ff @(posedge clk) begin
        if (en[k+2]) begin
          crd[k+2] <= crd[k+1];
        end
      end
    end
  end

  assign rsp.valid      = vld[LAST];
  assign rsp.src_offset = acc_src[LAST];
  assign rsp.dst_offset = acc_dst[LAST];
  assign rsp.action     = ctl[LAST].act;

endmodule
